/* hdl/fplvs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fplvs_pkg
// Types and constants for the flash page log variable store.
// ----------------------------------------------------------------------------
package fplvs_pkg;

  // Request kinds carried on the input word's tuser.
  localparam logic [1:0] REQ_CHECK = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Flash word values.
  localparam logic [63:0] HEADER_KEY  = 64'hBAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ERASED_WORD = 64'hFFFF_FFFF_FFFF_FFFF;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDREQ = 7'b0000100,
    S_RDCHK = 7'b0001000,
    S_FMT   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage : fplvs_pkg
`default_nettype wire

/* hdl/flash_page_log_variable_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// A request scans the page through a single-port slot memory: each slot is addressed
// (S_RDREQ), then checked (S_RDCHK); a format adds a sweep over every slot of the page,
// and a write adds the S_WR step. One request at a time; the next word can be taken in
// the cycle after the result is loaded, even while that result waits.
// Reset: synchronous, active low; afterward a clearing pass erases every slot of the
// page before the first request is taken.
// ----------------------------------------------------------------------------
// flash_page_log_variable_store
// One 64-bit variable kept as an append-only log in an emulated flash page.
// Each memory row is one slot: the first word in the low half, the second above.
// ----------------------------------------------------------------------------
module flash_page_log_variable_store
  import fplvs_pkg::*;
#(
  parameter int PAGE_SLOTS = 128
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input word.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // [63:0] write_value
  input  wire  [1:0]  in_tuser,   // [1:0] req_type
  // Result word.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata   // [63:0] read_value, [64] found, [65] reformatted,
                                  // [71:66] zero
);

  localparam int SW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(PAGE_SLOTS - 1);

  // Slot memory.
  logic [127:0] mem [PAGE_SLOTS];
  logic [127:0] rdata_r;
  logic [SW-1:0] mem_addr;
  logic [127:0]  mem_wdata;
  logic          mem_we;

  // Control and payload registers.
  state_t        state_r, state_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] last_r, last_nxt;
  logic          any_r, any_nxt;
  logic          recs_r, recs_nxt;
  logic          refmt_r, refmt_nxt;
  logic [63:0]   val_r, val_nxt;
  logic [1:0]    req_r;
  logic [63:0]   wval_r;
  logic          out_valid_r, out_valid_nxt;
  logic [71:0]   out_data_r;

  logic [63:0] w0, w1;
  logic        is_rec, is_erased, out_free;

  assign w0        = rdata_r[63:0];
  assign w1        = rdata_r[127:64];
  assign is_rec    = (w0 == ~w1);
  assign is_erased = (w0 == ERASED_WORD) && (w1 == ERASED_WORD);
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Memory port: one access per cycle, read data registered.
  always_comb begin
    mem_addr  = slot_r;
    mem_we    = 1'b0;
    mem_wdata = {ERASED_WORD, ERASED_WORD};
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_FMT: begin
        mem_we = 1'b1;
        if (slot_r == '0) begin
          mem_wdata = {64'd0, HEADER_KEY};
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_addr  = last_r + SW'(1);
        mem_wdata = {~wval_r, wval_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    last_nxt      = last_r;
    any_nxt       = any_r;
    recs_nxt      = recs_r;
    refmt_nxt     = refmt_r;
    val_nxt       = val_r;
    case (state_r)
      S_CLEAR: begin
        slot_nxt = slot_r + SW'(1);
        if (slot_r == LAST_SLOT) begin
          slot_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt  = '0;
          any_nxt   = 1'b0;
          recs_nxt  = 1'b1;
          refmt_nxt = 1'b0;
          val_nxt   = '0;
          if (in_tuser == REQ_CHECK) begin
            slot_nxt  = '0;
            state_nxt = S_RDREQ;
          end else if (in_tuser == REQ_READ || in_tuser == REQ_WRITE) begin
            slot_nxt  = SW'(1);
            state_nxt = S_RDREQ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RDREQ: begin
        state_nxt = S_RDCHK;
      end
      S_RDCHK: begin
        if (req_r == REQ_CHECK) begin
          // Header first, then records, then every later slot must be erased.
          if (slot_r == '0) begin
            if (w0 != HEADER_KEY) begin
              state_nxt = S_FMT;
            end else begin
              slot_nxt  = SW'(1);
              state_nxt = S_RDREQ;
            end
          end else if (recs_r && is_rec) begin
            last_nxt = slot_r;
            slot_nxt = slot_r + SW'(1);
            state_nxt = (slot_r == LAST_SLOT) ? S_DONE : S_RDREQ;
          end else begin
            recs_nxt = 1'b0;
            if (!is_erased) begin
              slot_nxt  = '0;
              state_nxt = S_FMT;
            end else begin
              slot_nxt  = slot_r + SW'(1);
              state_nxt = (slot_r == LAST_SLOT) ? S_DONE : S_RDREQ;
            end
          end
          if (state_nxt == S_FMT) begin
            slot_nxt = '0;
          end
        end else begin
          // Read and write: find the last record.
          if (is_rec) begin
            last_nxt = slot_r;
            any_nxt  = 1'b1;
            val_nxt  = w0;
            slot_nxt = slot_r + SW'(1);
          end
          if (!is_rec || slot_r == LAST_SLOT) begin
            if (req_r == REQ_READ) begin
              state_nxt = S_DONE;
            end else if (is_rec && slot_r == LAST_SLOT) begin
              slot_nxt  = '0;
              state_nxt = S_FMT;
            end else begin
              state_nxt = S_WR;
            end
          end else begin
            state_nxt = S_RDREQ;
          end
        end
      end
      S_FMT: begin
        slot_nxt = slot_r + SW'(1);
        if (slot_r == LAST_SLOT) begin
          slot_nxt  = '0;
          refmt_nxt = 1'b1;
          last_nxt  = '0;
          state_nxt = (req_r == REQ_WRITE) ? S_WR : S_DONE;
        end
      end
      S_WR: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register holds a result until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      slot_r      <= '0;
      last_r      <= '0;
      any_r       <= 1'b0;
      recs_r      <= 1'b0;
      refmt_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      last_r      <= last_nxt;
      any_r       <= any_nxt;
      recs_r      <= recs_nxt;
      refmt_r     <= refmt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (state_r == S_IDLE && in_tvalid) begin
      req_r  <= in_tuser;
      wval_r <= in_tdata;
    end
    if (state_r == S_DONE && out_free) begin
      if (req_r == REQ_READ) begin
        out_data_r <= {6'd0, refmt_r, any_r, val_r};
      end else begin
        out_data_r <= {6'd0, refmt_r, 1'b0, 64'd0};
      end
    end
  end

endmodule : flash_page_log_variable_store
`default_nettype wire
